### sv/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad press debouncer
// Field widths, command codes and the structs passed between the key lanes
// and the merge/output stage.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int KEY_W         = 16;  // width of key maps
  localparam int KEY_IDX_W     = 4;   // width of a key index
  localparam int TIME_W        = 32;  // timestamp width, wraps modulo 2^32
  localparam int DEB_W         = 8;   // debounce register width
  localparam int NUM_KEYS_DEF  = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd5;
  localparam logic [TIME_W-1:0] MIN_ELAPSED    = 32'd1;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // broadcast to every lane for the request being accepted
  typedef struct packed {
    logic                  sample;
    logic                  query;
    logic [TIME_W-1:0]     now_ms;
    logic [KEY_IDX_W-1:0]  key_index;
    logic [DEB_W-1:0]      debounce_ms;
  } lane_cmd_t;

  // per-lane result
  typedef struct packed {
    logic fired;     // query hit a set latch
    logic pend_nxt;  // latch after this request
    logic pend_q;    // latch currently held
  } lane_stat_t;

endpackage

### sv/kpd_if.sv
// ----------------------------------------------------------------------------
// kpd_if: valid/ready channels of the keypad press debouncer
// Request channel (sample or query) and result channel.
// ----------------------------------------------------------------------------
interface kpd_in_if;
  import kpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [TIME_W-1:0]     now_ms;
  logic [KEY_W-1:0]      pressed_keys;
  logic [KEY_IDX_W-1:0]  key_index;

  modport source (output valid, cmd, now_ms, pressed_keys, key_index, input ready);
  modport sink   (input valid, cmd, now_ms, pressed_keys, key_index, output ready);
endinterface

interface kpd_out_if;
  import kpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              fired;
  logic [KEY_W-1:0]  pending_keys;

  modport source (output valid, fired, pending_keys, input ready);
  modport sink   (input valid, fired, pending_keys, output ready);
endinterface

### sv/kpd_lane.sv
// ----------------------------------------------------------------------------
// kpd_lane: debounce state of one key
// Holds press start time, armed flag, pending latch and the previous level;
// ages the timer, detects edges and serves queries for its own index.
// ----------------------------------------------------------------------------
module kpd_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kpd_pkg::lane_cmd_t     cmd,
  input  logic                   key_now,
  output kpd_pkg::lane_stat_t    stat
);
  import kpd_pkg::*;

  logic [TIME_W-1:0] start_r, start_nxt;
  logic              armed_r, armed_nxt;
  logic              pend_r,  pend_nxt;
  logic              prev_r,  prev_nxt;

  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic              armed_aged;
  logic              pend_aged;
  logic              hit;

  assign elapsed    = cmd.now_ms - start_r;
  assign expired    = armed_r && (elapsed > {{(TIME_W-DEB_W){1'b0}}, cmd.debounce_ms});
  assign armed_aged = armed_r && !expired;
  // an elapsed time of one tick disarms without latching
  assign pend_aged  = pend_r || (expired && (elapsed > MIN_ELAPSED));
  assign hit        = cmd.query && (cmd.key_index == KEY_IDX_W'(LANE_IDX));

  always_comb begin
    start_nxt = start_r;
    armed_nxt = armed_r;
    pend_nxt  = pend_r;
    prev_nxt  = prev_r;
    if (cmd.sample) begin
      prev_nxt = key_now;
      if (key_now && !prev_r) begin
        start_nxt = cmd.now_ms;
        armed_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else if (!key_now && prev_r) begin
        armed_nxt = 1'b0;
        pend_nxt  = pend_aged;
      end else begin
        armed_nxt = armed_aged;
        pend_nxt  = pend_aged;
      end
    end else if (hit) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    if (!rst_n) begin
      armed_r <= 1'b0;
      pend_r  <= 1'b0;
      prev_r  <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      pend_r  <= pend_nxt;
      prev_r  <= prev_nxt;
    end
  end

  assign stat.fired    = hit && pend_r;
  assign stat.pend_nxt = pend_nxt;
  assign stat.pend_q   = pend_r;

endmodule

### sv/kpd_merge.sv
// ----------------------------------------------------------------------------
// kpd_merge: merges lane results and buffers the result channel
// ORs the lane fired bits, gathers the pending map and holds results in an
// output register backed by a one-entry skid register.
// ----------------------------------------------------------------------------
module kpd_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  kpd_pkg::lane_stat_t  lane_stat [kpd_pkg::KEY_W],
  output logic                 can_accept,
  kpd_out_if.source            out_ch
);
  import kpd_pkg::*;

  logic             fired_any;
  logic [KEY_W-1:0] pend_map;

  logic             ov_r, ov_nxt;
  logic             ofired_r, ofired_nxt;
  logic [KEY_W-1:0] opend_r, opend_nxt;
  logic             sv_r, sv_nxt;
  logic             sfired_r, sfired_nxt;
  logic [KEY_W-1:0] spend_r, spend_nxt;
  logic             pop;

  always_comb begin
    fired_any = 1'b0;
    for (int k = 0; k < KEY_W; k++) begin
      fired_any   = fired_any | lane_stat[k].fired;
      pend_map[k] = lane_stat[k].pend_nxt;
    end
  end

  assign pop        = ov_r && out_ch.ready;
  assign can_accept = !sv_r;

  always_comb begin
    ov_nxt     = ov_r;
    ofired_nxt = ofired_r;
    opend_nxt  = opend_r;
    sv_nxt     = sv_r;
    sfired_nxt = sfired_r;
    spend_nxt  = spend_r;
    if (pop) begin
      if (sv_r) begin
        ofired_nxt = sfired_r;
        opend_nxt  = spend_r;
        sv_nxt     = 1'b0;
      end else begin
        ov_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!ov_r || pop) begin
        ov_nxt     = 1'b1;
        ofired_nxt = fired_any;
        opend_nxt  = pend_map;
      end else begin
        sv_nxt     = 1'b1;
        sfired_nxt = fired_any;
        spend_nxt  = pend_map;
      end
    end
  end

  always_ff @(posedge clk) begin
    ofired_r <= ofired_nxt;
    opend_r  <= opend_nxt;
    sfired_r <= sfired_nxt;
    spend_r  <= spend_nxt;
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.fired        = ofired_r;
  assign out_ch.pending_keys = opend_r;

endmodule

### sv/keypad_press_debouncer.sv
// ----------------------------------------------------------------------------
// keypad_press_debouncer: hold-time debouncer for up to 16 keypad keys
// One lane per key ages its timer and detects edges; a merge stage builds
// the result.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : requests. cmd = sample carries now_ms and pressed_keys; a key
//            that stays pressed longer than debounce_ms ticks sets its
//            pending latch. cmd = query reads and clears key_index's latch.
//   out_ch : one result per request: fired (query only) and the pending map
//            after the request.
//   cfg_we / cfg_wdata : write debounce_ms; only while the block is idle.
// Output: results reach out_ch from the output register, never combinationally.
// Throughput: one request per cycle while in_ch.ready is high; all key lanes
//   update in the accept cycle, each with one 32-bit subtract and compare.
// Stall: an output register plus a one-entry skid register; in_ch.ready
//   drops only while both hold results the receiver has not taken.
// Reset (rst_n low, synchronous): all keys released and disarmed, latches
//   cleared, debounce_ms = 5, output and skid empty.
// ----------------------------------------------------------------------------
module keypad_press_debouncer #(
  parameter int NUM_KEYS = kpd_pkg::NUM_KEYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [kpd_pkg::DEB_W-1:0] cfg_wdata,
  kpd_in_if.sink                    in_ch,
  kpd_out_if.source                 out_ch
);
  import kpd_pkg::*;

  logic [DEB_W-1:0] debounce_r, debounce_nxt;
  logic             in_fire;
  logic             can_accept;
  lane_cmd_t        lane_cmd;
  lane_stat_t       lane_stat [KEY_W];
  logic [KEY_W-1:0] fired_vec;
  logic [KEY_W-1:0] pend_vec;

  assign debounce_nxt = cfg_we ? cfg_wdata : debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else begin
      debounce_r <= debounce_nxt;
    end
  end

  assign in_ch.ready = can_accept;
  assign in_fire     = in_ch.valid && can_accept;

  assign lane_cmd.sample      = in_fire && (in_ch.cmd == CMD_SAMPLE);
  assign lane_cmd.query       = in_fire && (in_ch.cmd == CMD_QUERY);
  assign lane_cmd.now_ms      = in_ch.now_ms;
  assign lane_cmd.key_index   = in_ch.key_index;
  assign lane_cmd.debounce_ms = debounce_r;

  for (genvar k = 0; k < KEY_W; k++) begin : g_lane
    if (k < NUM_KEYS) begin : g_key
      kpd_lane #(
        .LANE_IDX (k)
      ) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (lane_cmd),
        .key_now (in_ch.pressed_keys[k]),
        .stat    (lane_stat[k])
      );
    end else begin : g_none
      assign lane_stat[k] = '0;
    end
    assign fired_vec[k] = lane_stat[k].fired;
    assign pend_vec[k]  = lane_stat[k].pend_q;
  end

  kpd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .lane_stat  (lane_stat),
    .can_accept (can_accept),
    .out_ch     (out_ch)
  );

  // at most one lane answers a query
  a_fired_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(fired_vec))
    else $error("more than one lane fired");

  // a sample never reports fired
  a_sample_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    lane_cmd.sample |-> (fired_vec == '0))
    else $error("fired on a sample request");

  // skid full implies the output register is full
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("skid holds a result with empty output register");

  // a query clears the latch of its key
  a_query_clears: assert property (@(posedge clk) disable iff (!rst_n)
    lane_cmd.query |=> !pend_vec[$past(in_ch.key_index)])
    else $error("latch still set after query");

  // keys beyond NUM_KEYS never show as pending
  a_unused_keys: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.pending_keys >> NUM_KEYS) == '0))
    else $error("pending bit set for an absent key");

endmodule
